// File: design/bsctc_pkg.sv
`timescale 1ns / 1ps
package bsctc_pkg;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 19;
  localparam int REG_W      = 20;
  localparam int BYTE_W     = 8;
  localparam int BIT_SEL_W  = 3;
  localparam int BYTE_SHIFT = 3;
  localparam int BYTE_AW    = REG_W - BYTE_SHIFT;
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [BIT_SEL_W-1:0] BIT_SEL_MASK = 3'h7;
  localparam logic [REG_W-1:0]     LIMIT_RESET  = 20'd524288;
  localparam logic [REG_W-1:0]     FLOOR_RESET  = 20'd10000;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_COUNT = 2'd3
  } op_e;

  typedef enum logic {
    REG_INDEX_LIMIT = 1'b0,
    REG_COUNT_FLOOR = 1'b1
  } reg_e;

  typedef struct packed {
    logic clr_step;
    logic bit_start;
    logic bit_finish;
    logic cnt_start;
    logic cnt_issue;
    logic cnt_finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_empty;
    logic cnt_last;
    logic out_full;
  } sts_t;

endpackage

// File: design/bsctc_in_if.sv
`timescale 1ns / 1ps
interface bsctc_in_if;
  import bsctc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] bit_index;

  modport source (output valid, output operation, output bit_index, input ready);
  modport sink   (input valid, input operation, input bit_index, output ready);
endinterface

// File: design/bsctc_out_if.sv
`timescale 1ns / 1ps
interface bsctc_out_if;
  import bsctc_pkg::*;

  logic             valid;
  logic             ready;
  logic             bit_value;
  logic [REG_W-1:0] set_count;
  logic             in_range;

  modport source (output valid, output bit_value, output set_count, output in_range,
                  input ready);
  modport sink   (input valid, input bit_value, input set_count, input in_range,
                  output ready);
endinterface

// File: design/bsctc_cfg.sv
`timescale 1ns / 1ps
module bsctc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsctc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bsctc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bsctc_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  output logic [bsctc_pkg::REG_W-1:0]      index_limit_o,
  output logic [bsctc_pkg::REG_W-1:0]      count_floor_o
);
  import bsctc_pkg::*;

  logic [REG_W-1:0] limit_q, limit_d;
  logic [REG_W-1:0] floor_q, floor_d;
  logic             wr_en;
  reg_e             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    limit_d = limit_q;
    floor_d = floor_q;
    if (wr_en) begin
      case (reg_sel)
        REG_INDEX_LIMIT: limit_d = pwdata[REG_W-1:0];
        REG_COUNT_FLOOR: floor_d = pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      floor_q <= FLOOR_RESET;
    end else begin
      limit_q <= limit_d;
      floor_q <= floor_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_INDEX_LIMIT: prdata = APB_DATA_W'(limit_q);
      REG_COUNT_FLOOR: prdata = APB_DATA_W'(floor_q);
      default:         prdata = '0;
    endcase
  end

  assign index_limit_o = limit_q;
  assign count_floor_o = floor_q;
endmodule

// File: design/bsctc_ctrl.sv
`timescale 1ns / 1ps
module bsctc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [bsctc_pkg::OP_W-1:0] in_operation_i,
  output logic                       in_ready_o,
  output bsctc_pkg::cmd_t            cmd_o,
  input  bsctc_pkg::sts_t            sts_i
);
  import bsctc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT,
    ST_COUNT,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   accept;

  assign accept     = in_valid_i & ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
          ready_d = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ready_d = 1'b0;
          if (op_e'(in_operation_i) == OP_COUNT) begin
            cmd_o.cnt_start = 1'b1;
            state_d = sts_i.cnt_empty ? ST_FIN : ST_COUNT;
          end else begin
            cmd_o.bit_start = 1'b1;
            state_d = ST_BIT;
          end
        end
      end
      ST_BIT: begin
        if (!sts_i.out_full) begin
          cmd_o.bit_finish = 1'b1;
          state_d = ST_IDLE;
          ready_d = 1'b1;
        end
      end
      ST_COUNT: begin
        cmd_o.cnt_issue = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!sts_i.out_full) begin
          cmd_o.cnt_finish = 1'b1;
          state_d = ST_IDLE;
          ready_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !ready_q)
    else $error("input accepted during clearing pass");

  a_accept_drops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !ready_q)
    else $error("ready held after a transaction was taken");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.bit_finish || cmd_o.cnt_finish) |-> !sts_i.out_full)
    else $error("result loaded into a full output stage");
`endif
endmodule

// File: design/bsctc_dp.sv
`timescale 1ns / 1ps
module bsctc_dp #(
  parameter longint unsigned MAP_BITS = 524288
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsctc_pkg::cmd_t             cmd_i,
  output bsctc_pkg::sts_t             sts_o,
  input  logic [bsctc_pkg::OP_W-1:0]  in_operation_i,
  input  logic [bsctc_pkg::IDX_W-1:0] in_bit_index_i,
  input  logic [bsctc_pkg::REG_W-1:0] index_limit_i,
  input  logic [bsctc_pkg::REG_W-1:0] count_floor_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        bit_value_o,
  output logic [bsctc_pkg::REG_W-1:0] set_count_o,
  output logic                        in_range_o
);
  import bsctc_pkg::*;

  localparam longint unsigned DEPTH     = (MAP_BITS + 7) / 8;
  localparam longint unsigned REACH     = longint'(1) << BYTE_AW;
  localparam int              MEM_DEPTH = (DEPTH < REACH) ? int'(DEPTH) : int'(REACH);
  localparam int              AW        = $clog2(MEM_DEPTH);
  localparam longint unsigned REG_SPAN  = longint'(1) << REG_W;
  localparam longint unsigned MAP_CLAMP = (MAP_BITS < REG_SPAN) ? MAP_BITS : REG_SPAN;

  function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  logic [BYTE_W-1:0] mem_q [MEM_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              re;
  logic [AW-1:0]     ra;
  logic              we;
  logic [AW-1:0]     wa;
  logic [BYTE_W-1:0] wd;

  logic [AW-1:0]      clr_q;
  op_e                op_q;
  logic [IDX_W-1:0]   idx_q;
  logic               ok_q;
  logic [BYTE_AW-1:0] ptr_q;
  logic [BYTE_AW-1:0] rd_addr_q;
  logic               rd_valid_q;
  logic [REG_W-1:0]   acc_q;

  logic               out_valid_q;
  logic               bit_value_q;
  logic [REG_W-1:0]   set_count_q;
  logic               in_range_q;

  logic [REG_W-1:0]   eff_lim;
  logic [REG_W-1:0]   last_idx;
  logic [BYTE_AW-1:0] floor_byte;
  logic [BYTE_AW-1:0] last_byte;
  logic [BYTE_W-1:0]  bit_mask;
  logic [BYTE_W-1:0]  new_byte;
  logic               new_bit;
  logic               bit_write;
  logic [BYTE_W-1:0]  lo_mask;
  logic [BYTE_W-1:0]  hi_mask;
  logic               res_load;

  assign eff_lim    = ({1'b0, index_limit_i} < (REG_W + 1)'(MAP_CLAMP)) ?
                      index_limit_i : REG_W'(MAP_CLAMP);
  assign last_idx   = eff_lim - REG_W'(1);
  assign floor_byte = count_floor_i[REG_W-1:BYTE_SHIFT];
  assign last_byte  = last_idx[REG_W-1:BYTE_SHIFT];

  assign bit_mask  = BYTE_W'(1) << idx_q[BIT_SEL_W-1:0];
  assign bit_write = ok_q & ((op_q == OP_SET) | (op_q == OP_CLEAR));

  always_comb begin
    case (op_q)
      OP_SET:   new_byte = rdata_q | bit_mask;
      OP_CLEAR: new_byte = rdata_q & ~bit_mask;
      default:  new_byte = rdata_q;
    endcase
  end
  assign new_bit = |(new_byte & bit_mask);

  assign lo_mask = (rd_addr_q == floor_byte) ?
                   (8'hFF << count_floor_i[BIT_SEL_W-1:0]) : 8'hFF;
  assign hi_mask = (rd_addr_q == last_byte) ?
                   (8'hFF >> (BIT_SEL_MASK - last_idx[BIT_SEL_W-1:0])) : 8'hFF;

  assign re = cmd_i.bit_start | cmd_i.cnt_issue;
  assign ra = cmd_i.bit_start ? AW'(in_bit_index_i[IDX_W-1:BYTE_SHIFT]) : AW'(ptr_q);

  always_comb begin
    we = 1'b0;
    wa = clr_q;
    wd = '0;
    if (cmd_i.clr_step) begin
      we = 1'b1;
    end else if (cmd_i.bit_finish && bit_write) begin
      we = 1'b1;
      wa = AW'(idx_q[IDX_W-1:BYTE_SHIFT]);
      wd = new_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bit_start) begin
      op_q  <= op_e'(in_operation_i);
      idx_q <= in_bit_index_i;
      ok_q  <= ({1'b0, in_bit_index_i} < eff_lim);
    end
    if (cmd_i.cnt_start) begin
      ptr_q <= floor_byte;
    end else if (cmd_i.cnt_issue) begin
      ptr_q <= ptr_q + BYTE_AW'(1);
    end
    if (cmd_i.cnt_issue) begin
      rd_addr_q <= ptr_q;
    end
    if (cmd_i.cnt_start) begin
      acc_q <= '0;
    end else if (rd_valid_q) begin
      acc_q <= acc_q + REG_W'(popcount8(rdata_q & lo_mask & hi_mask));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.cnt_issue;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  assign res_load = cmd_i.bit_finish | cmd_i.cnt_finish;

  always_ff @(posedge clk_i) begin
    if (cmd_i.bit_finish) begin
      bit_value_q <= ok_q & new_bit;
      set_count_q <= '0;
      in_range_q  <= ok_q;
    end else if (cmd_i.cnt_finish) begin
      bit_value_q <= 1'b0;
      set_count_q <= acc_q;
      in_range_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.clr_last  = (clr_q == AW'(MEM_DEPTH - 1));
  assign sts_o.cnt_empty = (count_floor_i >= eff_lim);
  assign sts_o.cnt_last  = (ptr_q == last_byte);
  assign sts_o.out_full  = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign bit_value_o = bit_value_q;
  assign set_count_o = set_count_q;
  assign in_range_o  = in_range_q;

`ifndef SYNTHESIS
  a_write_only_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && !cmd_i.clr_step) |-> (ok_q && (op_q == OP_SET || op_q == OP_CLEAR)))
    else $error("map written by an out-of-range or read-only transaction");

  a_count_addr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (rd_addr_q >= floor_byte && rd_addr_q <= last_byte))
    else $error("count read outside the floor to limit window");

  a_count_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_finish |-> !rd_valid_q)
    else $error("count result taken with a read still in flight");
`endif
endmodule

// File: design/bitmap_set_clear_test_count_core.sv
`timescale 1ns / 1ps
// Check, set and clear: one synchronous read of the map byte, then, for an in-range set
// or clear, a write-back of the same byte; ready returns once the result is loaded.
// Count: reads the N bytes from floor/8 to (limit-1)/8, one byte read per cycle
// through the single map read port; none when the floor is at or above the limit.
// Reset: registers return to limit 524288 and floor 10000, then a clearing pass writes
// min(MAP_BITS/8, 131072) bytes, one per cycle (65536 by default), with input ready low.
module bitmap_set_clear_test_count_core #(
  parameter longint unsigned MAP_BITS = 524288
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bsctc_in_if.sink                         in_if,
  bsctc_out_if.source                      out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsctc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bsctc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bsctc_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import bsctc_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [REG_W-1:0] index_limit;
  logic [REG_W-1:0] count_floor;

  bsctc_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .index_limit_o (index_limit),
    .count_floor_o (count_floor)
  );

  bsctc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .in_operation_i (in_if.operation),
    .in_ready_o     (in_if.ready),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  bsctc_dp #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_operation_i (in_if.operation),
    .in_bit_index_i (in_if.bit_index),
    .index_limit_i  (index_limit),
    .count_floor_i  (count_floor),
    .out_ready_i    (out_if.ready),
    .out_valid_o    (out_if.valid),
    .bit_value_o    (out_if.bit_value),
    .set_count_o    (out_if.set_count),
    .in_range_o     (out_if.in_range)
  );
endmodule

// File: test/bitmap_set_clear_test_count_core_test.sv
`timescale 1ns / 1ps
module bitmap_set_clear_test_count_core_test;
  import bsctc_pkg::*;

  localparam longint unsigned MAP_SIZE    = 524288;
  localparam int              MAX_INDEX   = (1 << IDX_W) - 1;
  localparam int              CYCLE_LIMIT = 2_000_000;
  localparam int              PHASES      = 8;
  localparam int              PHASE_ITEMS = 88;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
  } op_item_t;

  typedef struct packed {
    logic             bit_value;
    logic [REG_W-1:0] set_count;
    logic             in_range;
  } map_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bsctc_in_if  in_ch ();
  bsctc_out_if out_ch ();

  bitmap_set_clear_test_count_core #(.MAP_BITS(MAP_SIZE)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch.sink),
    .out_if  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bit               bit_map [MAP_SIZE];
  logic [REG_W-1:0] limit_reg;
  logic [REG_W-1:0] floor_reg;

  op_item_t    pending_ops[$];
  map_result_t pending_results[$];

  int    send_idle_pct;
  int    recv_stall_pct;
  int    queued_total;
  int    accepted_total;
  int    fail_count;
  int    count_ops;
  int    out_of_range_ops;
  int    reg_writes;
  int    cycle_count;
  logic  in_taken;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic map_result_t apply_op(op_e op, logic [IDX_W-1:0] idx);
    map_result_t      r;
    longint unsigned  lim;
    int               n;
    lim = (limit_reg < MAP_SIZE) ? limit_reg : MAP_SIZE;
    n   = 0;
    r   = '0;
    r.in_range = 1'b1;
    if (op == OP_COUNT) begin
      for (longint unsigned i = floor_reg; i < lim; i++) n += bit_map[i];
      r.set_count = n[REG_W-1:0];
    end else if (idx < lim) begin
      if (op == OP_SET) bit_map[idx] = 1'b1;
      else if (op == OP_CLEAR) bit_map[idx] = 1'b0;
      r.bit_value = bit_map[idx];
    end else begin
      r.in_range = 1'b0;
    end
    return r;
  endfunction

  // driver: new transaction once the previous one was taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.operation <= pending_ops[0].op;
        in_ch.bit_index <= pending_ops[0].idx;
        void'(pending_ops.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk_i) begin
    map_result_t got;
    map_result_t want;
    in_taken <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.bit_value = out_ch.bit_value;
      got.set_count = out_ch.set_count;
      got.in_range  = out_ch.in_range;
      if (pending_results.size() == 0) begin
        $error("unexpected result: bit_value %0d set_count %0d in_range %0d",
               got.bit_value, got.set_count, got.in_range);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.bit_value !== want.bit_value) begin
          $error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
          fail_count++;
        end
        if (got.set_count !== want.set_count) begin
          $error("set_count: expected %0d, got %0d", want.set_count, got.set_count);
          fail_count++;
        end
        if (got.in_range !== want.in_range) begin
          $error("in_range: expected %0d, got %0d", want.in_range, got.in_range);
          fail_count++;
        end
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      want = apply_op(op_e'(in_ch.operation), in_ch.bit_index);
      pending_results.push_back(want);
      accepted_total <= accepted_total + 1;
      if (in_ch.operation == OP_COUNT) count_ops++;
      else if (!want.in_range) out_of_range_ops++;
    end
  end

  task automatic push_op(op_e op, int idx);
    op_item_t item;
    item.op  = op;
    item.idx = idx[IDX_W-1:0];
    pending_ops.push_back(item);
    queued_total++;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (accepted_total != queued_total || pending_results.size() != 0);
  endtask

  // write, then read back
  task automatic set_reg(reg_e r, int value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = APB_DATA_W'(value[REG_W-1:0]);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r == REG_INDEX_LIMIT) limit_reg = value[REG_W-1:0];
    else floor_reg = value[REG_W-1:0];
    reg_writes++;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(value[REG_W-1:0])) begin
      $error("prdata: expected %0d, got %0d", value[REG_W-1:0], prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    int    mode;
    int    lo_val;
    int    hi_val;
    int    win_lo;
    int    win_hi;
    int    idx;
    int    pick;
    op_e   op;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_CHECK;
    in_ch.bit_index = '0;
    out_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    queued_total    = 0;
    accepted_total  = 0;
    fail_count      = 0;
    count_ops       = 0;
    out_of_range_ops = 0;
    reg_writes      = 0;
    cycle_count     = 0;
    limit_reg       = LIMIT_RESET;
    floor_reg       = FLOOR_RESET;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values, both ends of the index range, floor boundary
    push_op(OP_CHECK, 0);
    push_op(OP_SET, 0);
    push_op(OP_CHECK, 0);
    push_op(OP_CLEAR, 0);
    push_op(OP_CHECK, 0);
    push_op(OP_SET, 9999);
    push_op(OP_SET, 10000);
    push_op(OP_SET, MAX_INDEX);
    push_op(OP_CHECK, MAX_INDEX);
    push_op(OP_COUNT, 0);
    push_op(OP_CLEAR, MAX_INDEX);
    push_op(OP_COUNT, MAX_INDEX);
    drain();

    // zero limit: everything out of range, floor above limit
    set_reg(REG_INDEX_LIMIT, 0);
    push_op(OP_SET, 5);
    push_op(OP_CHECK, 0);
    push_op(OP_COUNT, 0);
    drain();

    set_reg(REG_COUNT_FLOOR, 0);
    set_reg(REG_INDEX_LIMIT, 100);
    push_op(OP_SET, 99);
    push_op(OP_SET, 100);
    push_op(OP_CHECK, 100);
    push_op(OP_CHECK, 99);
    push_op(OP_COUNT, 0);
    drain();

    set_reg(REG_INDEX_LIMIT, int'(MAP_SIZE));
    set_reg(REG_COUNT_FLOOR, int'(MAP_SIZE));
    push_op(OP_COUNT, 0);
    drain();
    set_reg(REG_COUNT_FLOOR, 0);
    push_op(OP_COUNT, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      mode           = p % 4;
      send_idle_pct  = (mode == 1) ? 72 : (mode == 3) ? 24 : 0;
      recv_stall_pct = (mode == 2) ? 72 : (mode == 3) ? 24 : 0;
      case (p)
        0: begin
          lo_val = int'(MAP_SIZE) - 2048;
          hi_val = int'(MAP_SIZE);
        end
        3: begin
          hi_val = $urandom_range(64, 4000);
          lo_val = hi_val + $urandom_range(0, 200);
        end
        6: begin
          lo_val = 0;
          hi_val = $urandom_range(1, 1024);
        end
        default: begin
          lo_val = $urandom_range(0, int'(MAP_SIZE) - 1100);
          hi_val = lo_val + $urandom_range(1, 1024);
        end
      endcase
      set_reg(REG_COUNT_FLOOR, lo_val);
      set_reg(REG_INDEX_LIMIT, hi_val);
      win_lo = (lo_val < hi_val) ? lo_val : ((hi_val > 256) ? hi_val - 256 : 0);
      win_lo = (win_lo > 32) ? win_lo - 32 : 0;
      win_hi = (hi_val + 32 > MAX_INDEX) ? MAX_INDEX : hi_val + 32;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        op   = (pick < 35) ? OP_SET : (pick < 55) ? OP_CLEAR : (pick < 85) ? OP_CHECK : OP_COUNT;
        if ($urandom_range(0, 99) < 85) idx = $urandom_range(win_lo, win_hi);
        else idx = $urandom_range(0, MAX_INDEX);
        push_op(op, idx);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("run: %0d transactions, %0d counts, %0d out of range, %0d register writes",
             accepted_total, count_ops, out_of_range_ops, reg_writes);
    $display("idle phases: none, sender 72%%, receiver 72%%, both 24%%");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
